[src/dual_wheel_encoder_tachometer_macros.svh]
// assertion helpers used by the checker file
`ifndef DUAL_WHEEL_ENCODER_TACHOMETER_MACROS_SVH
`define DUAL_WHEEL_ENCODER_TACHOMETER_MACROS_SVH

// same-cycle implication, sampled on clk_i, quiet during reset
`define DWET_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, quiet during reset
`define DWET_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/dwet_pkg.sv]
`timescale 1ns / 1ps

package dwet_pkg;

  localparam int unsigned TIME_BITS  = 32;
  localparam int unsigned COUNT_BITS = 16;

  localparam int unsigned NPP_W  = 4;
  localparam int unsigned PPR_W  = 4;
  localparam int unsigned MS_W   = 16;
  localparam int unsigned CIRC_W = 8;
  localparam int unsigned RPM_W  = 14;
  localparam int unsigned SPEED_W = 22;
  localparam int unsigned AVG_W  = 16;

  // rpm divider: 60000 / (interval * pulses_per_rev)
  localparam int unsigned DIV_W     = TIME_BITS + PPR_W;
  localparam int unsigned QUO_W     = 16;
  localparam logic [QUO_W-1:0] DIVIDEND = 16'd60000;
  localparam int unsigned DIV_STEPS = QUO_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);
  localparam logic [RPM_W-1:0] RPM_MAX = {RPM_W{1'b1}};

  // speed: avg_rpm * circ * 256 / 60 = avg_rpm * circ * 64 / 15
  localparam int unsigned PROD_W      = RPM_W + CIRC_W;
  localparam int unsigned SPEED_SHIFT = 6;
  localparam int unsigned SPEED_DIV   = 15;
  localparam int unsigned SCALED_W    = PROD_W + SPEED_SHIFT;
  localparam int unsigned RECIP_SHIFT = 32;
  localparam int unsigned RECIP_W     = 29;
  localparam longint unsigned RECIP_VAL = ((64'd1 << RECIP_SHIFT) - 64'd1) / SPEED_DIV;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
  localparam int unsigned MULT_W  = SCALED_W + RECIP_W;
  localparam int unsigned QUOT_W  = MULT_W - RECIP_SHIFT;
  localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};

  // register port
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned DATA_W  = 32;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_EDGE  = 2'd1,
    FUNC_START = 2'd2,
    FUNC_STOP  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    REG_NPP    = 3'd0,
    REG_PPR    = 3'd1,
    REG_STALL  = 3'd2,
    REG_PERIOD = 3'd3,
    REG_CIRC   = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RPM,
    ST_WAIT,
    ST_MERGE,
    ST_SPEED,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [NPP_W-1:0]  npp;
    logic [PPR_W-1:0]  ppr;
    logic [MS_W-1:0]   stall;
    logic [MS_W-1:0]   period;
    logic [CIRC_W-1:0] circ;
  } cfg_t;

  localparam logic [NPP_W-1:0]  NPP_RESET    = 4'd4;
  localparam logic [PPR_W-1:0]  PPR_RESET    = 4'd5;
  localparam logic [MS_W-1:0]   STALL_RESET  = 16'd2000;
  localparam logic [MS_W-1:0]   PERIOD_RESET = 16'd1000;
  localparam logic [CIRC_W-1:0] CIRC_RESET   = 8'd22;

  typedef struct packed {
    func_e func;
    logic  left_edge;
    logic  right_edge;
  } in_item_t;

  typedef struct packed {
    logic [RPM_W-1:0]   left_rpm;
    logic [RPM_W-1:0]   right_rpm;
    logic [SPEED_W-1:0] speed_q8;
    logic [AVG_W-1:0]   wheel_count_avg;
    logic [AVG_W-1:0]   window_notch_avg;
    logic               window_valid;
  } out_item_t;

  typedef struct packed {
    logic edge_upd;
    logic edge_seen;
    logic win_count;
    logic win_clear;
    logic rpm_start;
  } lane_cmd_t;

  typedef struct packed {
    logic                  busy;
    logic [RPM_W-1:0]      rpm;
    logic [COUNT_BITS-1:0] edges;
    logic [COUNT_BITS-1:0] win;
  } lane_res_t;

  function automatic logic [AVG_W-1:0] half_sum(logic [COUNT_BITS-1:0] a,
                                                logic [COUNT_BITS-1:0] b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return AVG_W'(s[COUNT_BITS:1]);
  endfunction

endpackage

[src/dwet_lane.sv]
`timescale 1ns / 1ps

module dwet_lane import dwet_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lane_cmd_t            cmd_i,
  input  cfg_t                 cfg_i,
  input  logic [TIME_BITS-1:0] time_i,
  output lane_res_t            res_o
);

  logic [NPP_W-1:0]      notch_q, notch_d;
  logic [TIME_BITS-1:0]  start_q, start_d;
  logic [TIME_BITS-1:0]  interval_q, interval_d;
  logic [RPM_W-1:0]      rpm_q, rpm_d;
  logic [COUNT_BITS-1:0] edges_q, edges_d;
  logic [COUNT_BITS-1:0] win_q, win_d;
  logic                  busy_q, busy_d;
  logic [STEP_W-1:0]     step_q, step_d;

  logic                  ok_q, ok_d;
  logic [DIV_W-1:0]      divisor_q, divisor_d;
  logic [QUO_W-1:0]      rem_q, rem_d;
  logic [QUO_W-1:0]      dvd_q, dvd_d;
  logic [QUO_W-1:0]      quo_q, quo_d;

  logic [NPP_W-1:0]      notch_inc;
  logic                  pulse;
  logic [TIME_BITS-1:0]  age;
  logic [QUO_W:0]        rem_sh;
  logic                  fits;
  logic [QUO_W-1:0]      quo_nx;

  always_comb begin
    notch_inc = notch_q + NPP_W'(cmd_i.edge_seen);
    pulse     = (notch_inc == cfg_i.npp);
    age       = time_i - start_q;
    rem_sh    = {rem_q, dvd_q[QUO_W-1]};
    fits      = (divisor_q[DIV_W-1:QUO_W+1] == '0) && (rem_sh >= divisor_q[QUO_W:0]);
    quo_nx    = {quo_q[QUO_W-2:0], fits};

    notch_d    = notch_q;
    start_d    = start_q;
    interval_d = interval_q;
    rpm_d      = rpm_q;
    edges_d    = edges_q;
    win_d      = win_q;
    busy_d     = busy_q;
    step_d     = step_q;
    ok_d       = ok_q;
    divisor_d  = divisor_q;
    rem_d      = rem_q;
    dvd_d      = dvd_q;
    quo_d      = quo_q;

    // edges first, then the pulse check on the updated count
    if (cmd_i.edge_upd) begin
      edges_d = edges_q + COUNT_BITS'(cmd_i.edge_seen);
      if (cmd_i.win_count && cmd_i.edge_seen) begin
        win_d = win_q + COUNT_BITS'(1);
      end
      if (pulse) begin
        notch_d    = '0;
        interval_d = age;
        start_d    = time_i;
      end else begin
        notch_d = notch_inc;
      end
    end

    if (cmd_i.win_clear) begin
      win_d = '0;
    end

    // restoring divide, one quotient bit a cycle
    if (cmd_i.rpm_start) begin
      ok_d      = (age <= TIME_BITS'(cfg_i.stall)) && (interval_q != '0) && (cfg_i.ppr != '0);
      divisor_d = DIV_W'(interval_q) * DIV_W'(cfg_i.ppr);
      rem_d     = '0;
      dvd_d     = DIVIDEND;
      quo_d     = '0;
      step_d    = '0;
      busy_d    = 1'b1;
    end else if (busy_q) begin
      rem_d  = fits ? QUO_W'(rem_sh - divisor_q[QUO_W:0]) : QUO_W'(rem_sh);
      dvd_d  = dvd_q << 1;
      quo_d  = quo_nx;
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        if (!ok_q) begin
          rpm_d = '0;
        end else if (quo_nx > QUO_W'(RPM_MAX)) begin
          rpm_d = RPM_MAX;
        end else begin
          rpm_d = RPM_W'(quo_nx);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      notch_q    <= '0;
      start_q    <= '0;
      interval_q <= '0;
      rpm_q      <= '0;
      edges_q    <= '0;
      win_q      <= '0;
      busy_q     <= 1'b0;
      step_q     <= '0;
    end else begin
      notch_q    <= notch_d;
      start_q    <= start_d;
      interval_q <= interval_d;
      rpm_q      <= rpm_d;
      edges_q    <= edges_d;
      win_q      <= win_d;
      busy_q     <= busy_d;
      step_q     <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q      <= ok_d;
    divisor_q <= divisor_d;
    rem_q     <= rem_d;
    dvd_q     <= dvd_d;
    quo_q     <= quo_d;
  end

  assign res_o = '{busy: busy_q, rpm: rpm_q, edges: edges_q, win: win_q};

endmodule

[src/dwet_merge.sv]
`timescale 1ns / 1ps

module dwet_merge import dwet_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                go_i,
  input  lane_res_t           left_i,
  input  lane_res_t           right_i,
  input  logic [CIRC_W-1:0]   circ_i,
  output logic [SPEED_W-1:0]  speed_o,
  output logic [AVG_W-1:0]    cnt_avg_o,
  output logic                done_o
);

  logic [2:0]            v_q;
  logic [PROD_W-1:0]     prod_q;
  logic [SCALED_W-1:0]   scaled_q;
  logic [MULT_W-1:0]     mult_q;
  logic [AVG_W-1:0]      cnt_q;
  logic [SPEED_W-1:0]    speed_q;

  logic [RPM_W:0]        rpm_sum;
  logic [SCALED_W-1:0]   scaled;
  logic [QUOT_W-1:0]     q0;
  logic [QUOT_W+3:0]     back;
  logic [SCALED_W-1:0]   rem;
  logic [QUOT_W-1:0]     q1;
  logic [SPEED_W-1:0]    speed_d;

  always_comb begin
    rpm_sum = {1'b0, left_i.rpm} + {1'b0, right_i.rpm};
    scaled  = {prod_q, {SPEED_SHIFT{1'b0}}};
    // reciprocal estimate is exact or one short
    q0      = mult_q[MULT_W-1:RECIP_SHIFT];
    back    = {q0, 4'b0000} - {4'b0000, q0};
    rem     = scaled_q - SCALED_W'(back);
    q1      = q0 + QUOT_W'(rem >= SCALED_W'(SPEED_DIV));
    speed_d = (q1 > QUOT_W'(SPEED_MAX)) ? SPEED_MAX : SPEED_W'(q1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[1:0], go_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      prod_q <= PROD_W'(rpm_sum[RPM_W:1]) * PROD_W'(circ_i);
      cnt_q  <= half_sum(left_i.edges, right_i.edges);
    end
    if (v_q[0]) begin
      scaled_q <= scaled;
      mult_q   <= MULT_W'(scaled) * MULT_W'(RECIP);
    end
    if (v_q[1]) begin
      speed_q <= speed_d;
    end
  end

  assign speed_o   = speed_q;
  assign cnt_avg_o = cnt_q;
  assign done_o    = v_q[2];

endmodule

[src/dual_wheel_encoder_tachometer.sv]
`timescale 1ns / 1ps

// two-wheel encoder tachometer: each input transaction is a millisecond tick, a
// pair of encoder edge flags, or a start/stop command for a notch-count window, and
// every input transaction yields exactly one output transaction carrying both
// wheel rpms, the speed in q8 cm/s, the average edge count and the window report.
// the two wheels run in separate lanes; when the update period expires each lane
// works out 60000 / (interval * pulses_per_rev) in its own 16-step restoring
// divider, and a merge stage then forms the speed through a reciprocal multiply.
// one transaction is in flight at a time: an ordinary transaction passes the
// merge stage into the output register before the next one can be taken; a tick
// that triggers the rpm update also waits for the divider loop in the lanes
// (start, 16 steps and the handover back to the sequencer). the output register
// lets a finished result wait while the next input is already taken.
// registers sit on an apb-style port at byte addresses 0, 4, 8, 12 and 16; they
// should only be written while the block is idle.

module dual_wheel_encoder_tachometer import dwet_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_data_i,

  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_data_o,

  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  // sequencer state and shared timing
  state_e               state_q, state_d;
  logic [TIME_BITS-1:0] time_q, time_d;
  logic [MS_W-1:0]      period_q, period_d;
  logic [MS_W-1:0]      period_inc;
  logic                 win_active_q, win_active_d;

  // window report latched at acceptance, before the lanes clear their counts
  logic [AVG_W-1:0]     win_avg_q, win_avg_d;
  logic                 win_valid_q, win_valid_d;

  // configuration
  cfg_t                 cfg_q, cfg_d;
  logic                 cfg_wr;

  // output register
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_data_q, out_data_d;
  logic                 out_load;

  // lanes and merge
  lane_cmd_t            cmd_l, cmd_r;
  lane_res_t            res_l, res_r;
  logic                 merge_go;
  logic                 merge_done;
  logic [SPEED_W-1:0]   merge_speed;
  logic [AVG_W-1:0]     merge_cnt;

  logic                 accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign period_inc = period_q + MS_W'(1);

  // sequencer
  always_comb begin
    state_d      = state_q;
    time_d       = time_q;
    period_d     = period_q;
    win_active_d = win_active_q;
    win_avg_d    = win_avg_q;
    win_valid_d  = win_valid_q;
    cmd_l        = '0;
    cmd_r        = '0;
    merge_go     = 1'b0;
    out_load     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          win_avg_d   = '0;
          win_valid_d = 1'b0;
          state_d     = ST_MERGE;
          case (in_data_i.func)
            FUNC_TICK: begin
              time_d = time_q + TIME_BITS'(1);
              // period of zero updates on every tick
              if (period_inc >= cfg_q.period) begin
                period_d = '0;
                state_d  = ST_RPM;
              end else begin
                period_d = period_inc;
              end
            end
            FUNC_EDGE: begin
              cmd_l.edge_upd  = 1'b1;
              cmd_l.edge_seen = in_data_i.left_edge;
              cmd_l.win_count = win_active_q;
              cmd_r.edge_upd  = 1'b1;
              cmd_r.edge_seen = in_data_i.right_edge;
              cmd_r.win_count = win_active_q;
            end
            FUNC_START: begin
              win_active_d = 1'b1;
            end
            FUNC_STOP: begin
              // stop with no open window reports nothing
              if (win_active_q) begin
                win_active_d    = 1'b0;
                win_avg_d       = half_sum(res_l.win, res_r.win);
                win_valid_d     = 1'b1;
                cmd_l.win_clear = 1'b1;
                cmd_r.win_clear = 1'b1;
              end
            end
            default: begin
              state_d = ST_MERGE;
            end
          endcase
        end
      end
      ST_RPM: begin
        cmd_l.rpm_start = 1'b1;
        cmd_r.rpm_start = 1'b1;
        state_d         = ST_WAIT;
      end
      ST_WAIT: begin
        if (!res_l.busy && !res_r.busy) begin
          state_d = ST_MERGE;
        end
      end
      ST_MERGE: begin
        merge_go = 1'b1;
        state_d  = ST_SPEED;
      end
      ST_SPEED: begin
        if (merge_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        // hold here while the previous result still waits downstream
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_data_d  = '{left_rpm:         res_l.rpm,
                      right_rpm:        res_r.rpm,
                      speed_q8:         merge_speed,
                      wheel_count_avg:  merge_cnt,
                      window_notch_avg: win_avg_q,
                      window_valid:     win_valid_q};
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // register port
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (reg_idx_e'(paddr[PADDR_W-1:2]))
        REG_NPP:    cfg_d.npp    = pwdata[NPP_W-1:0];
        REG_PPR:    cfg_d.ppr    = pwdata[PPR_W-1:0];
        REG_STALL:  cfg_d.stall  = pwdata[MS_W-1:0];
        REG_PERIOD: cfg_d.period = pwdata[MS_W-1:0];
        REG_CIRC:   cfg_d.circ   = pwdata[CIRC_W-1:0];
        default:    cfg_d        = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[PADDR_W-1:2]))
      REG_NPP:    prdata = DATA_W'(cfg_q.npp);
      REG_PPR:    prdata = DATA_W'(cfg_q.ppr);
      REG_STALL:  prdata = DATA_W'(cfg_q.stall);
      REG_PERIOD: prdata = DATA_W'(cfg_q.period);
      REG_CIRC:   prdata = DATA_W'(cfg_q.circ);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q       <= '0;
      period_q     <= '0;
      win_active_q <= 1'b0;
      win_valid_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      cfg_q        <= '{npp:    NPP_RESET,
                        ppr:    PPR_RESET,
                        stall:  STALL_RESET,
                        period: PERIOD_RESET,
                        circ:   CIRC_RESET};
    end else begin
      time_q       <= time_d;
      period_q     <= period_d;
      win_active_q <= win_active_d;
      win_valid_q  <= win_valid_d;
      out_valid_q  <= out_valid_d;
      cfg_q        <= cfg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_avg_q  <= win_avg_d;
    out_data_q <= out_data_d;
  end

  // wheel lanes
  dwet_lane u_lane_left (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_l),
    .cfg_i  (cfg_q),
    .time_i (time_q),
    .res_o  (res_l)
  );

  dwet_lane u_lane_right (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_r),
    .cfg_i  (cfg_q),
    .time_i (time_q),
    .res_o  (res_r)
  );

  // speed and averages from both lanes
  dwet_merge u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .go_i      (merge_go),
    .left_i    (res_l),
    .right_i   (res_r),
    .circ_i    (cfg_q.circ),
    .speed_o   (merge_speed),
    .cnt_avg_o (merge_cnt),
    .done_o    (merge_done)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[src/dwet_checker.sv]
`timescale 1ns / 1ps
`include "dual_wheel_encoder_tachometer_macros.svh"

module dwet_checker import dwet_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  // a stalled result stays offered
  `DWET_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped while stalled")

  // one transaction in flight: no acceptance in the cycle after one
  `DWET_ASSERT_NXT(a_one_at_a_time, in_valid_i && in_ready_o, !in_ready_o, "input taken back to back")

  // window average only reported with a closed window
  `DWET_ASSERT_IMP(a_win_zero, out_valid_o && !out_data_o.window_valid, out_data_o.window_notch_avg == '0, "window average without window")

  // both wheels stopped means no speed
  `DWET_ASSERT_IMP(a_speed_zero, out_valid_o && out_data_o.left_rpm == '0 && out_data_o.right_rpm == '0, out_data_o.speed_q8 == '0, "speed with both wheels at rest")

endmodule

bind dual_wheel_encoder_tachometer dwet_checker u_checker (.*);

[dv/dual_wheel_encoder_tachometer_tb.sv]
`timescale 1ns / 1ps

module dual_wheel_encoder_tachometer_tb;
  import dwet_pkg::*;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // input channel
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  in_item_t in_data_i  = '0;

  // output channel
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;

  // register port
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0]  pwdata  = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  dual_wheel_encoder_tachometer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // 8 ns period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // tachometer state as the testbench sees it, updated once per accepted
  // input transaction; the configuration copy follows every register write
  // ---------------------------------------------------------------------------
  cfg_t                  cfg_now;
  logic [TIME_BITS-1:0]  ms_clock;
  logic [15:0]           period_ticks;
  logic [NPP_W-1:0]      notch_cnt[2];
  logic [TIME_BITS-1:0]  pulse_t0[2];
  logic [TIME_BITS-1:0]  pulse_gap[2];
  logic [RPM_W-1:0]      rpm_now[2];
  logic [COUNT_BITS-1:0] win_cnt[2];
  logic [COUNT_BITS-1:0] edge_cnt[2];
  logic                  window_open;

  // transactions waiting to be driven, and readings predicted for them
  in_item_t  tx_backlog[$];
  out_item_t predicted_readings[$];
  int        items_queued = 0;
  int        items_taken  = 0;
  int        mismatches   = 0;

  // idling control: 0 means no gaps at all, higher means more frequent gaps
  int        jitter   = 2;
  int        drv_gap  = 0;
  int        rcv_gap  = 0;
  bit        hold_go  = 1'b0;
  logic      hold_off = 1'b0;

  // works out the reading that one input transaction produces
  function automatic out_item_t tacho_predict(in_item_t it);
    out_item_t            r;
    logic [TIME_BITS-1:0] age;
    longint unsigned      q;
    longint unsigned      avg;
    longint unsigned      spd;
    bit [1:0]             hit;
    r = '0;
    hit[0] = it.left_edge;
    hit[1] = it.right_edge;
    case (it.func)
      FUNC_TICK: begin
        ms_clock     = ms_clock + 1'b1;
        period_ticks = period_ticks + 1'b1;
        // a zero period refreshes on every tick
        if (period_ticks >= cfg_now.period) begin
          period_ticks = '0;
          for (int w = 0; w < 2; w++) begin
            age = ms_clock - pulse_t0[w];
            q   = 0;
            // stalled wheel, zero interval or zero pulses per rev all give 0
            if (age <= cfg_now.stall && pulse_gap[w] != 0 && cfg_now.ppr != 0) begin
              q = 64'd60000 / pulse_gap[w];
              q = q / cfg_now.ppr;
              if (q > RPM_MAX) q = RPM_MAX;
            end
            rpm_now[w] = q[RPM_W-1:0];
          end
        end
      end
      FUNC_EDGE: begin
        for (int w = 0; w < 2; w++) begin
          if (hit[w]) begin
            notch_cnt[w] = notch_cnt[w] + 1'b1;
            edge_cnt[w]  = edge_cnt[w] + 1'b1;
            if (window_open) win_cnt[w] = win_cnt[w] + 1'b1;
          end
        end
        // a wheel sitting at the pulse count fires whether or not it moved
        for (int w = 0; w < 2; w++) begin
          if (notch_cnt[w] == cfg_now.npp) begin
            pulse_gap[w] = ms_clock - pulse_t0[w];
            pulse_t0[w]  = ms_clock;
            notch_cnt[w] = '0;
          end
        end
      end
      FUNC_START: begin
        window_open = 1'b1;
      end
      FUNC_STOP: begin
        // a stop with no open window reports nothing
        if (window_open) begin
          window_open        = 1'b0;
          avg                = (64'(win_cnt[0]) + win_cnt[1]) >> 1;
          r.window_notch_avg = avg[AVG_W-1:0];
          r.window_valid     = 1'b1;
          win_cnt[0]         = '0;
          win_cnt[1]         = '0;
        end
      end
      default: ;
    endcase
    avg = (64'(rpm_now[0]) + rpm_now[1]) >> 1;
    spd = avg * cfg_now.circ * 256 / 60;
    if (spd > SPEED_MAX) spd = SPEED_MAX;
    r.left_rpm        = rpm_now[0];
    r.right_rpm       = rpm_now[1];
    r.speed_q8        = spd[SPEED_W-1:0];
    avg               = (64'(edge_cnt[0]) + edge_cnt[1]) >> 1;
    r.wheel_count_avg = avg[AVG_W-1:0];
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers the backlog on the input channel, predicts on acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predicted_readings.push_back(tacho_predict(in_data_i));
        items_taken++;
      end
      // the slot is free once nothing is offered or the offer was just taken
      if (!in_valid_i || in_ready_o) begin
        if (drv_gap > 0) begin
          drv_gap--;
          in_valid_i <= 1'b0;
        end else if (tx_backlog.size() > 0 && jitter > 0 &&
                     $urandom_range(0, 7) < jitter) begin
          drv_gap = $urandom_range(0, 15);
          in_valid_i <= 1'b0;
        end else if (tx_backlog.size() > 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= tx_backlog.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks every output transaction against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (predicted_readings.size() == 0) begin
          $error("output transaction with no reading predicted");
          mismatches++;
        end else begin
          out_item_t want;
          want = predicted_readings.pop_front();
          check_field("left_rpm", want.left_rpm, out_data_o.left_rpm);
          check_field("right_rpm", want.right_rpm, out_data_o.right_rpm);
          check_field("speed_q8", want.speed_q8, out_data_o.speed_q8);
          check_field("wheel_count_avg", want.wheel_count_avg, out_data_o.wheel_count_avg);
          check_field("window_notch_avg", want.window_notch_avg,
                      out_data_o.window_notch_avg);
          check_field("window_valid", want.window_valid, out_data_o.window_valid);
        end
      end
      if (hold_off) begin
        out_ready_i <= 1'b0;
      end else if (rcv_gap > 0) begin
        rcv_gap--;
        out_ready_i <= 1'b0;
      end else if (jitter > 0 && $urandom_range(0, 7) < jitter) begin
        rcv_gap = $urandom_range(0, 15);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // long receiver hold-off, so that the block backs up and stalls its input
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_item(func_e f, bit l, bit r);
    in_item_t it;
    it.func       = f;
    it.left_edge  = l;
    it.right_edge = r;
    tx_backlog.push_back(it);
    items_queued++;
  endfunction

  // mostly ticks and edges so that pulses, updates and stalls all happen;
  // window commands come in at random, pairs broken or repeated included
  function automatic void queue_random(int n);
    int    pick;
    func_e f;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      f = (pick < 45) ? FUNC_TICK  :
          (pick < 88) ? FUNC_EDGE  :
          (pick < 94) ? FUNC_START : FUNC_STOP;
      queue_item(f, $urandom_range(0, 1), $urandom_range(0, 1));
    end
  endfunction

  // setup cycle then access cycle; written when the access phase completes
  task automatic write_reg(reg_idx_e idx, logic [DATA_W-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(int'(idx) * 4);
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_NPP:    cfg_now.npp    = val[NPP_W-1:0];
      REG_PPR:    cfg_now.ppr    = val[PPR_W-1:0];
      REG_STALL:  cfg_now.stall  = val[MS_W-1:0];
      REG_PERIOD: cfg_now.period = val[MS_W-1:0];
      REG_CIRC:   cfg_now.circ   = val[CIRC_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int unsigned npp, int unsigned ppr, int unsigned stall,
                            int unsigned period, int unsigned circ);
    write_reg(REG_NPP, npp);
    write_reg(REG_PPR, ppr);
    write_reg(REG_STALL, stall);
    write_reg(REG_PERIOD, period);
    write_reg(REG_CIRC, circ);
  endtask

  // block is idle once every transaction is taken and every reading checked
  task automatic wait_drained();
    do @(posedge clk_i);
    while (items_taken != items_queued || predicted_readings.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    cfg_now.npp    = NPP_RESET;
    cfg_now.ppr    = PPR_RESET;
    cfg_now.stall  = STALL_RESET;
    cfg_now.period = PERIOD_RESET;
    cfg_now.circ   = CIRC_RESET;
    ms_clock       = '0;
    period_ticks   = '0;
    window_open    = 1'b0;
    for (int w = 0; w < 2; w++) begin
      notch_cnt[w] = '0;
      pulse_t0[w]  = '0;
      pulse_gap[w] = '0;
      rpm_now[w]   = '0;
      win_cnt[w]   = '0;
      edge_cnt[w]  = '0;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: window commands in every order, each edge combination,
    // the left wheel reaching its pulse count
    queue_item(FUNC_STOP, 1'b0, 1'b0);
    queue_item(FUNC_START, 1'b1, 1'b1);
    queue_item(FUNC_START, 1'b0, 1'b0);
    queue_item(FUNC_EDGE, 1'b1, 1'b0);
    queue_item(FUNC_EDGE, 1'b0, 1'b1);
    queue_item(FUNC_EDGE, 1'b1, 1'b1);
    queue_item(FUNC_EDGE, 1'b0, 1'b0);
    queue_item(FUNC_TICK, 1'b1, 1'b1);
    queue_item(FUNC_EDGE, 1'b1, 1'b1);
    queue_item(FUNC_EDGE, 1'b1, 1'b0);
    queue_item(FUNC_STOP, 1'b1, 1'b1);
    queue_item(FUNC_STOP, 1'b0, 1'b0);
    wait_drained();

    // one notch per pulse, one pulse per rev, updates every tick: a 1 ms
    // interval saturates the rpm and the speed, two pulses in the same
    // millisecond give a zero interval
    set_config(1, 1, 65535, 1, 255);
    queue_item(FUNC_TICK, 1'b0, 1'b0);
    queue_item(FUNC_EDGE, 1'b1, 1'b1);
    queue_item(FUNC_TICK, 1'b0, 1'b0);
    queue_item(FUNC_EDGE, 1'b1, 1'b1);
    queue_item(FUNC_TICK, 1'b0, 1'b0);
    queue_item(FUNC_EDGE, 1'b1, 1'b1);
    queue_item(FUNC_EDGE, 1'b1, 1'b1);
    queue_item(FUNC_TICK, 1'b0, 1'b0);
    wait_drained();

    // opposite extremes: hardly any pulses, near-instant stall, rare updates
    jitter = 1;
    set_config(15, 15, 1, 65535, 1);
    queue_random(100);
    wait_drained();

    // all-zero settings: zero divisor, refresh every tick, leftover notch
    // counters above the pulse count climbing round
    set_config(0, 0, 0, 0, 0);
    queue_random(60);
    wait_drained();

    // random settings with short periods so the rpm moves a lot
    for (int ph = 0; ph < 6; ph++) begin
      jitter = $urandom_range(0, 3);
      set_config($urandom_range(1, 4), $urandom_range(1, 15), $urandom_range(2, 300),
                 $urandom_range(1, 12), $urandom_range(0, 255));
      queue_random(120);
      if (ph == 1) hold_go = 1'b1;
      wait_drained();
    end

    // closing stretch at full rate, no gaps on either side
    jitter = 0;
    set_config($urandom_range(1, 3), $urandom_range(1, 15), $urandom_range(5, 200),
               $urandom_range(1, 6), $urandom_range(1, 255));
    queue_random(150);
    wait_drained();

    // allow any stray transaction to show up
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("dual_wheel_encoder_tachometer_tb: clean");
    end else begin
      $display("dual_wheel_encoder_tachometer_tb: errors");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5000000;
    $display("dual_wheel_encoder_tachometer_tb: errors");
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/dwet_pkg.sv
src/dwet_lane.sv
src/dwet_merge.sv
src/dual_wheel_encoder_tachometer.sv
src/dwet_checker.sv
dv/dual_wheel_encoder_tachometer_tb.sv
